@@ rtl/core/dtbp_pkg.sv @@
// Shared types, constants and codes of the dual token-bucket policer.
`timescale 1ns / 1ps
`default_nettype none

package dtbp_pkg;

	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int DEF_TIME_BITS     = 32;

	localparam int LEVEL_W     = 32;
	localparam int MTU_W       = 23;
	localparam int VAL_W       = LEVEL_W + 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

	// Effective MTU in cells when the MTU register is zero.
	localparam logic [7:0] SAT_CELLS = 8'd255;

	typedef enum logic [1:0] {
		OP_PACKET   = 2'd0,
		OP_RATE_WR  = 2'd1,
		OP_PEAK_WR  = 2'd2,
		OP_RESTART  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BURST        = 3'd0,
		CFG_MTU          = 3'd1,
		CFG_RATE_LOG     = 3'd2,
		CFG_PEAK_LOG     = 3'd3,
		CFG_RATE_EN      = 3'd4,
		CFG_PEAK_EN      = 3'd5,
		CFG_CONFORM_CODE = 3'd6,
		CFG_EXCEED_CODE  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] burst;
		logic [15:0]        mtu;
		logic [3:0]         rate_log;
		logic [3:0]         peak_log;
		logic               rate_en;
		logic               peak_en;
		logic [7:0]         conform_code;
		logic [7:0]         exceed_code;
	} cfg_t;

	// One classified item with its table costs, as it travels to the back end.
	typedef struct packed {
		op_t                op;
		logic               over_mtu;
		logic [31:0]        now;
		logic [LEVEL_W-1:0] rate_cost;
		logic [LEVEL_W-1:0] peak_cost;
		logic [LEVEL_W-1:0] peak_cap;
	} work_t;

	typedef struct packed {
		logic              empty;
		logic [QLVL_W-1:0] level;
	} q_stat_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EVAL = 1'b1
	} bk_state_t;

endpackage

`default_nettype wire

@@ rtl/core/dtbp_if.sv @@
// Valid/ready channel interfaces for policer items and results.
`timescale 1ns / 1ps
`default_nettype none

interface dtbp_item_if import dtbp_pkg::*; ();
	logic        valid;
	logic        ready;
	op_t         op;
	logic [15:0] packet_length;
	logic [31:0] now_time;
	logic [7:0]  table_index;
	logic [31:0] table_value;

	modport source (output valid, op, packet_length, now_time, table_index, table_value,
		input ready);
	modport sink (input valid, op, packet_length, now_time, table_index, table_value,
		output ready);
endinterface

interface dtbp_result_if import dtbp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [7:0]         verdict;
	logic               conformed;
	logic [LEVEL_W-1:0] rate_tokens_left;
	logic [LEVEL_W-1:0] peak_tokens_left;

	modport source (output valid, verdict, conformed, rate_tokens_left, peak_tokens_left,
		input ready);
	modport sink (input valid, verdict, conformed, rate_tokens_left, peak_tokens_left,
		output ready);
endinterface

`default_nettype wire

@@ rtl/core/dtbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dtbp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dtbp_front.sv @@
// Front end: accepts items, writes the cost tables and looks up packet costs.
`timescale 1ns / 1ps
`default_nettype none

module dtbp_front import dtbp_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	dtbp_item_if.sink    items,
	input  wire q_stat_t q_stat,
	output logic         push,
	output work_t        push_entry
);

	localparam int          IDX_W   = $clog2(TABLE_ENTRIES);
	localparam logic [31:0] IDX_MAX = 32'(TABLE_ENTRIES - 1);

	function automatic logic [IDX_W-1:0] cost_index(input logic [MTU_W-1:0] len,
			input logic [3:0] shamt);
		logic [31:0] sh;
		sh = 32'(len) >> shamt;
		return (sh > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : sh[IDX_W-1:0];
	endfunction

	logic               accept;
	logic [MTU_W-1:0]   eff_mtu;
	logic [MTU_W-1:0]   len_ext;
	logic [31:0]        tidx_ext;
	logic               tidx_ok;
	logic               rate_we;
	logic               peak_we;
	logic [LEVEL_W-1:0] rate_rd;
	logic [LEVEL_W-1:0] peak_len_rd;
	logic [LEVEL_W-1:0] peak_mtu_rd;

	logic               valid_s1;
	op_t                op_s1;
	logic               over_s1;
	logic [31:0]        now_s1;

	// A slot is reserved for the beat in flight so that stage one never stalls.
	assign items.ready = ((QLVL_W + 1)'(q_stat.level) + (QLVL_W + 1)'(valid_s1))
		< (QLVL_W + 1)'(QUEUE_DEPTH);
	assign accept = items.valid && items.ready;

	assign eff_mtu  = (cfg.mtu != '0) ? MTU_W'(cfg.mtu) : (MTU_W'(SAT_CELLS) << cfg.rate_log);
	assign len_ext  = MTU_W'(items.packet_length);
	assign tidx_ext = 32'(items.table_index);
	assign tidx_ok  = tidx_ext < 32'(TABLE_ENTRIES);
	assign rate_we  = accept && (items.op == OP_RATE_WR) && tidx_ok;
	assign peak_we  = accept && (items.op == OP_PEAK_WR) && tidx_ok;

	dtbp_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_ENTRIES)) u_rate_tab (
		.clk   (clk),
		.we    (rate_we),
		.waddr (tidx_ext[IDX_W-1:0]),
		.wdata (items.table_value),
		.re    (accept),
		.raddr (cost_index(len_ext, cfg.rate_log)),
		.rdata (rate_rd)
	);

	// The peak table is kept twice so the length and MTU costs read in parallel.
	dtbp_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_ENTRIES)) u_peak_len_tab (
		.clk   (clk),
		.we    (peak_we),
		.waddr (tidx_ext[IDX_W-1:0]),
		.wdata (items.table_value),
		.re    (accept),
		.raddr (cost_index(len_ext, cfg.peak_log)),
		.rdata (peak_len_rd)
	);

	dtbp_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_ENTRIES)) u_peak_mtu_tab (
		.clk   (clk),
		.we    (peak_we),
		.waddr (tidx_ext[IDX_W-1:0]),
		.wdata (items.table_value),
		.re    (accept),
		.raddr (cost_index(eff_mtu, cfg.peak_log)),
		.rdata (peak_mtu_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= items.op;
			over_s1 <= len_ext > eff_mtu;
			now_s1  <= items.now_time;
		end
	end

	assign push       = valid_s1;
	assign push_entry = '{op: op_s1, over_mtu: over_s1, now: now_s1, rate_cost: rate_rd,
		peak_cost: peak_len_rd, peak_cap: peak_mtu_rd};

endmodule

`default_nettype wire

@@ rtl/core/dtbp_queue.sv @@
// Short FIFO that decouples the front end from the bucket evaluator.
`timescale 1ns / 1ps
`default_nettype none

module dtbp_queue import dtbp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire work_t push_entry,
	input  wire logic  pop,
	output work_t      head,
	output q_stat_t    q_stat
);

	work_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QLVL_W-1:0] level_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

	assign head         = slot_q[rptr_q];
	assign q_stat.empty = (level_q == '0);
	assign q_stat.level = level_q;

endmodule

`default_nettype wire

@@ rtl/core/dtbp_back.sv @@
// Back end: refills and charges both buckets and registers one result per item.
`timescale 1ns / 1ps
`default_nettype none

module dtbp_back import dtbp_pkg::*; #(
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire work_t   head,
	input  wire q_stat_t q_stat,
	output logic         pop,
	dtbp_result_if.source results
);

	localparam int CMP_W = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W;

	bk_state_t state_q, state_d;

	logic [LEVEL_W-1:0]   rate_level_q;
	logic [LEVEL_W-1:0]   peak_level_q;
	logic [TIME_BITS-1:0] last_time_q;

	// First evaluation cycle results.
	work_t              entry_q;
	logic [LEVEL_W-1:0] elapsed_q;
	logic [VAL_W-1:0]   rate_diff_q;
	logic [VAL_W-1:0]   rate_cap_diff_q;
	logic [VAL_W-1:0]   peak_diff_q;
	logic [VAL_W-1:0]   peak_cap_diff_q;

	logic [TIME_BITS-1:0] head_now;
	logic [TIME_BITS-1:0] delta;
	logic [LEVEL_W-1:0]   elapsed;

	logic                 commit;
	logic                 out_free;
	logic                 rate_over;
	logic                 peak_over;
	logic [VAL_W-1:0]     toks;
	logic [VAL_W-1:0]     ptoks;
	logic                 fits;
	logic                 ok;
	logic                 upd_levels;
	logic                 upd_time;
	logic [LEVEL_W-1:0]   rate_next;
	logic [LEVEL_W-1:0]   peak_next;
	logic [7:0]           verdict_next;
	logic                 conformed_next;

	logic                 out_valid_q;
	logic [7:0]           verdict_q;
	logic                 conformed_q;
	logic [LEVEL_W-1:0]   rate_out_q;
	logic [LEVEL_W-1:0]   peak_out_q;

	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		commit  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = BK_EVAL;
				end
			end
			BK_EVAL: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = BK_IDLE;
				end
			end
		endcase
	end

	// Elapsed time is the wrapped distance from the stored time, capped at the burst.
	assign head_now = TIME_BITS'(head.now);
	assign delta    = head_now - last_time_q;
	assign elapsed  = (CMP_W'(delta) > CMP_W'(cfg.burst)) ? cfg.burst : LEVEL_W'(delta);

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q         <= head;
			elapsed_q       <= elapsed;
			rate_diff_q     <= VAL_W'(rate_level_q) - VAL_W'(head.rate_cost);
			rate_cap_diff_q <= VAL_W'(cfg.burst) - VAL_W'(head.rate_cost);
			peak_diff_q     <= VAL_W'(peak_level_q) - VAL_W'(head.peak_cost);
			peak_cap_diff_q <= VAL_W'(head.peak_cap) - VAL_W'(head.peak_cost);
		end
	end

	// min(level + elapsed, cap) - cost, formed as a choice of two precomputed differences.
	assign rate_over = (33'(rate_level_q) + 33'(elapsed_q)) > 33'(cfg.burst);
	assign peak_over = (33'(peak_level_q) + 33'(elapsed_q)) > 33'(entry_q.peak_cap);
	assign toks  = rate_over ? rate_cap_diff_q : rate_diff_q + VAL_W'(elapsed_q);
	assign ptoks = !cfg.peak_en ? '0
		: (peak_over ? peak_cap_diff_q : peak_diff_q + VAL_W'(elapsed_q));
	assign fits  = !toks[VAL_W-1] && !ptoks[VAL_W-1];

	always_comb begin
		ok             = 1'b0;
		upd_levels     = 1'b0;
		upd_time       = 1'b0;
		rate_next      = rate_level_q;
		peak_next      = peak_level_q;
		verdict_next   = '0;
		conformed_next = 1'b0;
		unique case (entry_q.op)
			OP_PACKET: begin
				if (!entry_q.over_mtu) begin
					if (!cfg.rate_en) begin
						ok = 1'b1;
					end else if (fits) begin
						ok         = 1'b1;
						upd_levels = 1'b1;
						upd_time   = 1'b1;
						rate_next  = toks[LEVEL_W-1:0];
						peak_next  = ptoks[LEVEL_W-1:0];
					end
				end
				verdict_next   = ok ? cfg.conform_code : cfg.exceed_code;
				conformed_next = ok;
			end
			OP_RESTART: begin
				upd_levels = 1'b1;
				upd_time   = 1'b1;
				rate_next  = cfg.burst;
				peak_next  = cfg.peak_en ? entry_q.peak_cap : '0;
			end
			OP_RATE_WR, OP_PEAK_WR: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_level_q <= '0;
			peak_level_q <= '0;
			last_time_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (commit && upd_levels) begin
				rate_level_q <= rate_next;
				peak_level_q <= peak_next;
			end
			if (commit && upd_time) begin
				last_time_q <= TIME_BITS'(entry_q.now);
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			verdict_q   <= verdict_next;
			conformed_q <= conformed_next;
			rate_out_q  <= rate_next;
			peak_out_q  <= peak_next;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.verdict          = verdict_q;
	assign results.conformed        = conformed_q;
	assign results.rate_tokens_left = rate_out_q;
	assign results.peak_tokens_left = peak_out_q;

endmodule

`default_nettype wire

@@ rtl/core/dual_token_bucket_policer.sv @@
// Top level of the dual token-bucket policer: configuration registers and the two halves.
`timescale 1ns / 1ps
`default_nettype none

// Each beat on items is a packet, a cost table write or a bucket restart, and each
// yields exactly one beat on results in order. The front end takes a beat every cycle
// while its four-entry queue has room, writes the cost tables and reads the packet's
// rate cost, peak cost and peak cap from three table RAMs in parallel. The back end
// evaluates one item in two states, IDLE and EVAL, because the bucket levels read when
// the item is popped are written when it commits, so it takes no new item before the
// last one has committed. The result sits in an output register, so a stalled results
// channel does not stop the front end until the queue fills. Configuration is written
// through cfg_we, cfg_index and cfg_wdata and must only change while no item is in
// flight.
module dual_token_bucket_policer import dtbp_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int TIME_BITS     = DEF_TIME_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	dtbp_item_if.sink                  items,
	dtbp_result_if.source              results
);

	cfg_t    cfg_q;
	logic    push;
	work_t   push_entry;
	logic    pop;
	work_t   head;
	q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{burst: '0, mtu: '0, rate_log: '0, peak_log: '0, rate_en: 1'b0,
				peak_en: 1'b0, conform_code: '0, exceed_code: 8'd2};
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BURST:        cfg_q.burst        <= cfg_wdata[LEVEL_W-1:0];
				CFG_MTU:          cfg_q.mtu          <= cfg_wdata[15:0];
				CFG_RATE_LOG:     cfg_q.rate_log     <= cfg_wdata[3:0];
				CFG_PEAK_LOG:     cfg_q.peak_log     <= cfg_wdata[3:0];
				CFG_RATE_EN:      cfg_q.rate_en      <= cfg_wdata[0];
				CFG_PEAK_EN:      cfg_q.peak_en      <= cfg_wdata[0];
				CFG_CONFORM_CODE: cfg_q.conform_code <= cfg_wdata[7:0];
				CFG_EXCEED_CODE:  cfg_q.exceed_code  <= cfg_wdata[7:0];
			endcase
		end
	end

	dtbp_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.items      (items),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	dtbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	dtbp_back #(.TIME_BITS(TIME_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.results (results)
	);

endmodule

`default_nettype wire
